[rtl/core/swdl_pkg.sv]
// ----------------------------------------------------------------------------
// swdl_pkg: shared types for the sliding window duty limiter
// Payload structs, microcode word layout, the control program and the
// interface structs between the sequencer, the ring store and the divider.
// ----------------------------------------------------------------------------
package swdl_pkg;

	localparam int BUCKET_COUNT = 8;              // power of two
	localparam int IDX_W        = $clog2(BUCKET_COUNT);
	localparam int SPAN_W       = IDX_W + 1;      // holds 0..BUCKET_COUNT
	localparam int SLOT_W       = 16;
	localparam logic [SLOT_W-1:0] SLOT_MAX = 16'hFFFF;
	localparam int SUM_W        = SLOT_W + IDX_W;
	localparam int TIME_W       = 32;
	localparam int PERIOD_W     = 16;
	localparam int WINDOW_W     = 23;
	localparam int USED_W       = 22;
	// dividend width; a gap below window + one period fits only while that sum stays within 23 bits
	localparam int DIVD_W       = 23;
	localparam int DCNT_W       = $clog2(DIVD_W + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_PERIOD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ON_TIME   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_OFF_TIME  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BUDGET = 3'd4;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic              want_open;
		logic [TIME_W-1:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic              gate_open;
		logic [USED_W-1:0] window_used_ms;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_TAKE   = 4'd0,
		OP_INIT   = 4'd1,
		OP_RDCUR  = 4'd2,
		OP_ACC    = 4'd3,
		OP_CLRCHK = 4'd4,
		OP_DIV    = 4'd5,
		OP_ROT    = 4'd6,
		OP_SUM0   = 4'd7,
		OP_SUM    = 4'd8,
		OP_SUMEND = 4'd9,
		OP_DEC    = 4'd10,
		OP_OUT    = 4'd11,
		OP_NOP    = 4'd12
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT     = 3'd0,
		C_ALWAYS   = 3'd1,
		C_NO_IN    = 3'd2,
		C_CLR      = 3'd3,
		C_DIV_BUSY = 3'd4,
		C_CNT_MORE = 3'd5,
		C_OUT_BUSY = 3'd6
	} cond_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t P_IDLE = 4'd0;
	localparam pc_t P_DIV  = 4'd5;
	localparam pc_t P_SUM0 = 4'd7;
	localparam pc_t P_SUM  = 4'd8;
	localparam pc_t P_OUT  = 4'd11;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} uword_t;

	typedef struct packed {
		logic in_valid;
		logic clr;
		logic div_busy;
		logic cnt_more;
		logic out_busy;
	} seq_flags_t;

	typedef struct packed {
		logic              rd_en;
		idx_t              rd_addr;
		logic              wr_en;
		idx_t              wr_addr;
		logic [SLOT_W-1:0] wr_data;
		logic              clr_all;
		logic              clr_span;
		idx_t              span_base;
		logic [SPAN_W-1:0] span_len;
	} ring_req_t;

	typedef struct packed {
		logic              busy;
		logic [DIVD_W-1:0] quo;
		logic [PERIOD_W-1:0] rem;
	} div_res_t;

	// control program: jump to target when the condition holds, else step on
	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		case (pc)
			4'd0:    w = '{op: OP_TAKE,   cond: C_NO_IN,    target: P_IDLE};
			4'd1:    w = '{op: OP_INIT,   cond: C_NEXT,     target: P_IDLE};
			4'd2:    w = '{op: OP_RDCUR,  cond: C_NEXT,     target: P_IDLE};
			4'd3:    w = '{op: OP_ACC,    cond: C_NEXT,     target: P_IDLE};
			4'd4:    w = '{op: OP_CLRCHK, cond: C_CLR,      target: P_SUM0};
			4'd5:    w = '{op: OP_DIV,    cond: C_DIV_BUSY, target: P_DIV};
			4'd6:    w = '{op: OP_ROT,    cond: C_NEXT,     target: P_IDLE};
			4'd7:    w = '{op: OP_SUM0,   cond: C_NEXT,     target: P_IDLE};
			4'd8:    w = '{op: OP_SUM,    cond: C_CNT_MORE, target: P_SUM};
			4'd9:    w = '{op: OP_SUMEND, cond: C_NEXT,     target: P_IDLE};
			4'd10:   w = '{op: OP_DEC,    cond: C_NEXT,     target: P_IDLE};
			4'd11:   w = '{op: OP_OUT,    cond: C_OUT_BUSY, target: P_OUT};
			default: w = '{op: OP_NOP,    cond: C_ALWAYS,   target: P_IDLE};
		endcase
		return w;
	endfunction

endpackage

[rtl/core/swdl_seq.sv]
// ----------------------------------------------------------------------------
// swdl_seq: microcode sequencer
// Step counter, control store lookup and conditional jump.
// ----------------------------------------------------------------------------
module swdl_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swdl_pkg::seq_flags_t flags,
	output swdl_pkg::uword_t     ctl
);

	swdl_pkg::pc_t pc_q;
	logic          jump;

	assign ctl = swdl_pkg::ucode(pc_q);

	always_comb begin
		case (ctl.cond)
			swdl_pkg::C_NEXT:     jump = 1'b0;
			swdl_pkg::C_ALWAYS:   jump = 1'b1;
			swdl_pkg::C_NO_IN:    jump = !flags.in_valid;
			swdl_pkg::C_CLR:      jump = flags.clr;
			swdl_pkg::C_DIV_BUSY: jump = flags.div_busy;
			swdl_pkg::C_CNT_MORE: jump = flags.cnt_more;
			swdl_pkg::C_OUT_BUSY: jump = flags.out_busy;
			default:              jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= swdl_pkg::P_IDLE;
		end else if (jump) begin
			pc_q <= ctl.target;
		end else begin
			pc_q <= pc_q + swdl_pkg::pc_t'(1);
		end
	end

endmodule

[rtl/core/swdl_div.sv]
// ----------------------------------------------------------------------------
// swdl_div: restoring divider, one quotient bit per cycle
// Splits the bucket gap into whole periods and a remainder.
// ----------------------------------------------------------------------------
module swdl_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [swdl_pkg::DIVD_W-1:0]     dividend,
	input  logic [swdl_pkg::PERIOD_W-1:0]   divisor,
	output swdl_pkg::div_res_t              res
);

	logic [swdl_pkg::DCNT_W-1:0]   cnt_q;
	logic [swdl_pkg::DIVD_W-1:0]   quo_q;
	logic [swdl_pkg::PERIOD_W-1:0] rem_q;
	logic [swdl_pkg::PERIOD_W-1:0] dvs_q;
	logic [swdl_pkg::PERIOD_W:0]   trial;
	logic                          fits;

	assign trial = {rem_q, quo_q[swdl_pkg::DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= swdl_pkg::DCNT_W'(swdl_pkg::DIVD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - swdl_pkg::DCNT_W'(1);
		end
	end

	// shift one dividend bit into the partial remainder per step
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[swdl_pkg::DIVD_W-2:0], fits};
			rem_q <= fits ? swdl_pkg::PERIOD_W'(trial - {1'b0, dvs_q})
			              : trial[swdl_pkg::PERIOD_W-1:0];
		end
	end

	assign res.busy = cnt_q != '0;
	assign res.quo  = quo_q;
	assign res.rem  = rem_q;

endmodule

[rtl/core/swdl_ring.sv]
// ----------------------------------------------------------------------------
// swdl_ring: bucket history store
// One write and one registered read per cycle; per-entry valid bits make
// cleared entries read as zero.
// ----------------------------------------------------------------------------
module swdl_ring (
	input  logic                        clk,
	input  logic                        arst_n,
	input  swdl_pkg::ring_req_t         req,
	output logic [swdl_pkg::SLOT_W-1:0] rd_data
);

	logic [swdl_pkg::SLOT_W-1:0]     mem [swdl_pkg::BUCKET_COUNT];
	logic [swdl_pkg::BUCKET_COUNT-1:0] vld_q;
	logic [swdl_pkg::BUCKET_COUNT-1:0] span_mask;
	logic [swdl_pkg::SLOT_W-1:0]     rd_q;
	logic                            rd_vld_q;

	// entries base+1 .. base+len, all of them at full length
	always_comb begin
		for (int j = 0; j < swdl_pkg::BUCKET_COUNT; j++) begin
			logic [swdl_pkg::IDX_W-1:0] offs;
			offs = swdl_pkg::IDX_W'(j) - req.span_base;
			span_mask[j] = (req.span_len == swdl_pkg::SPAN_W'(swdl_pkg::BUCKET_COUNT))
			            || (offs != '0 && {1'b0, offs} <= req.span_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clr_all) begin
				vld_q <= '0;
			end else if (req.clr_span) begin
				vld_q <= vld_q & ~span_mask;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : '0;

endmodule

[rtl/core/sliding_window_duty_limiter_unit.sv]
// ----------------------------------------------------------------------------
// sliding_window_duty_limiter_unit: bucketed sliding-window duty limiter
// Gates a load against a maximum on-time, a minimum off-time and an open-time
// budget over a ring of history buckets. A microcoded sequencer walks a
// plain datapath through accumulate, rotate, sum and decide.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  cfg     | in        | cfg_we                | cfg_idx, cfg_wdata
//  in      | in        | in_valid / in_ready   | in_data (want_open, now_ms)
//  out     | out       | out_valid / out_ready | out_data (gate_open, used)
//
//  A request runs take, init, read, accumulate, clear check, divide, rotate,
//  sum and decide to a loaded result; a gap that wipes the whole ring skips
//  divide and rotate, so the 23-step period divider sets the long case.
//  in_ready is high in the idle step only, so the next request is accepted only after the last result is loaded.
//  A stalled output holds the sequencer in its final step; no extra buffer.
//  Reset clears the history valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sliding_window_duty_limiter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [swdl_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [swdl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  swdl_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output swdl_pkg::out_item_t               out_data
);

	localparam int TW = swdl_pkg::TIME_W;

	// configuration
	logic [swdl_pkg::PERIOD_W-1:0] period_q;
	logic [swdl_pkg::WINDOW_W-1:0] window_q;
	logic [TW-1:0]                 max_on_q;
	logic [TW-1:0]                 min_off_q;
	logic [TW-1:0]                 budget_q;

	// limiter state
	logic                          init_q;
	logic                          open_q;
	logic [TW-1:0]                 opened_q;
	logic [TW-1:0]                 closed_q;
	logic [TW-1:0]                 last_q;
	logic [TW-1:0]                 bstart_q;
	swdl_pkg::idx_t                cur_q;

	// per-request scratch
	logic                          want_q;
	logic [TW-1:0]                 now_q;
	logic [TW-1:0]                 delta_q;
	logic [TW-1:0]                 gap_q;
	logic                          clr_q;
	logic [swdl_pkg::SUM_W-1:0]    sum_q;
	swdl_pkg::idx_t                cnt_q;
	logic                          on_exp_q;
	logic                          off_ok_q;
	logic                          over_q;

	logic                          out_valid_q;
	swdl_pkg::out_item_t           out_q;

	swdl_pkg::uword_t              ctl;
	swdl_pkg::seq_flags_t          flags;
	swdl_pkg::ring_req_t           ring_req;
	swdl_pkg::div_res_t            div_res;
	logic [swdl_pkg::SLOT_W-1:0]   ring_rd;

	logic [swdl_pkg::PERIOD_W-1:0] period_eff;
	logic [TW-1:0]                 wipe_limit;
	logic [swdl_pkg::SLOT_W-1:0]   add_amt;
	logic [swdl_pkg::SLOT_W:0]     slot_sum;
	logic                          div_start;
	logic                          out_free;
	logic                          next_open;
	logic                          take;

	// ---------------------------------------------------------------- control
	swdl_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = ctl.op == swdl_pkg::OP_TAKE;
	assign take     = in_valid && in_ready;

	assign flags.in_valid = in_valid;
	assign flags.clr      = clr_q;
	assign flags.div_busy = div_res.busy;
	assign flags.cnt_more = cnt_q != swdl_pkg::idx_t'(swdl_pkg::BUCKET_COUNT - 1);
	assign flags.out_busy = !out_free;

	// ------------------------------------------------------------ arithmetic
	// a zero period counts as one millisecond
	assign period_eff = (period_q == '0) ? swdl_pkg::PERIOD_W'(1) : period_q;
	assign wipe_limit = TW'(window_q) + TW'(period_eff);

	// open time since the last request, capped to one bucket's range
	assign add_amt  = (delta_q[TW-1:swdl_pkg::SLOT_W] != '0) ? swdl_pkg::SLOT_MAX
	                                                         : delta_q[swdl_pkg::SLOT_W-1:0];
	assign slot_sum = {1'b0, ring_rd} + {1'b0, add_amt};

	assign div_start = ctl.op == swdl_pkg::OP_CLRCHK && !clr_q;

	swdl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (gap_q[swdl_pkg::DIVD_W-1:0]),
		.divisor  (period_eff),
		.res      (div_res)
	);

	// ------------------------------------------------------------ ring access
	always_comb begin
		ring_req           = '0;
		ring_req.wr_addr   = cur_q;
		ring_req.wr_data   = slot_sum[swdl_pkg::SLOT_W] ? swdl_pkg::SLOT_MAX
		                                                : slot_sum[swdl_pkg::SLOT_W-1:0];
		ring_req.span_base = cur_q;
		ring_req.span_len  = (div_res.quo >= swdl_pkg::DIVD_W'(swdl_pkg::BUCKET_COUNT))
		                   ? swdl_pkg::SPAN_W'(swdl_pkg::BUCKET_COUNT)
		                   : div_res.quo[swdl_pkg::SPAN_W-1:0];
		ring_req.rd_addr   = cur_q;
		case (ctl.op)
			swdl_pkg::OP_INIT: begin
				ring_req.clr_all = !init_q;
			end
			swdl_pkg::OP_RDCUR: begin
				ring_req.rd_en = 1'b1;
			end
			swdl_pkg::OP_ACC: begin
				ring_req.wr_en = open_q && delta_q != '0;
			end
			swdl_pkg::OP_CLRCHK: begin
				ring_req.clr_all = clr_q;
			end
			swdl_pkg::OP_ROT: begin
				ring_req.clr_span = 1'b1;
			end
			swdl_pkg::OP_SUM0: begin
				ring_req.rd_en   = 1'b1;
				ring_req.rd_addr = '0;
			end
			swdl_pkg::OP_SUM: begin
				ring_req.rd_en   = 1'b1;
				ring_req.rd_addr = cnt_q;
			end
			default: begin
			end
		endcase
	end

	swdl_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ring_req),
		.rd_data (ring_rd)
	);

	// -------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= swdl_pkg::PERIOD_W'(1000);
			window_q  <= swdl_pkg::WINDOW_W'(8000);
			max_on_q  <= TW'(30000);
			min_off_q <= TW'(1000);
			budget_q  <= TW'(4000);
		end else if (cfg_we) begin
			case (cfg_idx)
				swdl_pkg::CFG_BUCKET_PERIOD: period_q  <= cfg_wdata[swdl_pkg::PERIOD_W-1:0];
				swdl_pkg::CFG_WINDOW_LENGTH: window_q  <= cfg_wdata[swdl_pkg::WINDOW_W-1:0];
				swdl_pkg::CFG_MAX_ON_TIME:   max_on_q  <= cfg_wdata[TW-1:0];
				swdl_pkg::CFG_MIN_OFF_TIME:  min_off_q <= cfg_wdata[TW-1:0];
				swdl_pkg::CFG_WINDOW_BUDGET: budget_q  <= cfg_wdata[TW-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------- gate decision
	always_comb begin
		next_open = open_q;
		if (open_q) begin
			if (!want_q || on_exp_q || over_q) begin
				next_open = 1'b0;
			end
		end else if (want_q && off_ok_q && !over_q) begin
			next_open = 1'b1;
		end
	end

	// ----------------------------------------------------------- limiter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= 1'b0;
			open_q      <= 1'b0;
			opened_q    <= '0;
			closed_q    <= '0;
			last_q      <= '0;
			bstart_q    <= '0;
			cur_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (ctl.op)
				swdl_pkg::OP_INIT: begin
					// first request: start closed, backdate the last close
					if (!init_q) begin
						init_q   <= 1'b1;
						open_q   <= 1'b0;
						opened_q <= now_q;
						closed_q <= now_q - min_off_q;
						last_q   <= now_q;
						bstart_q <= now_q;
						cur_q    <= '0;
					end
				end
				swdl_pkg::OP_ACC: begin
					last_q <= now_q;
				end
				swdl_pkg::OP_CLRCHK: begin
					// gap of at least the window plus one period: restart the ring here
					if (clr_q) begin
						bstart_q <= now_q;
						cur_q    <= '0;
					end
				end
				swdl_pkg::OP_ROT: begin
					// advance by whole periods; the remainder is time into the bucket
					cur_q    <= cur_q + div_res.quo[swdl_pkg::IDX_W-1:0];
					bstart_q <= now_q - TW'(div_res.rem);
				end
				swdl_pkg::OP_OUT: begin
					if (out_free) begin
						open_q <= next_open;
						if (open_q && !next_open) begin
							closed_q <= now_q;
						end
						if (!open_q && next_open) begin
							opened_q <= now_q;
						end
					end
				end
				default: begin
				end
			endcase

			if (ctl.op == swdl_pkg::OP_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------- scratch
	always_ff @(posedge clk) begin
		case (ctl.op)
			swdl_pkg::OP_TAKE: begin
				if (in_valid) begin
					want_q <= in_data.want_open;
					now_q  <= in_data.now_ms;
				end
			end
			swdl_pkg::OP_RDCUR: begin
				delta_q <= now_q - last_q;
				gap_q   <= now_q - bstart_q;
			end
			swdl_pkg::OP_ACC: begin
				clr_q <= gap_q >= wipe_limit;
			end
			swdl_pkg::OP_SUM0: begin
				sum_q <= '0;
				cnt_q <= swdl_pkg::idx_t'(1);
			end
			swdl_pkg::OP_SUM: begin
				sum_q <= sum_q + swdl_pkg::SUM_W'(ring_rd);
				cnt_q <= cnt_q + swdl_pkg::idx_t'(1);
			end
			swdl_pkg::OP_SUMEND: begin
				sum_q <= sum_q + swdl_pkg::SUM_W'(ring_rd);
			end
			swdl_pkg::OP_DEC: begin
				on_exp_q <= (now_q - opened_q) >= max_on_q;
				off_ok_q <= (now_q - closed_q) >= min_off_q;
				over_q   <= TW'(sum_q) >= budget_q;
			end
			swdl_pkg::OP_OUT: begin
				if (out_free) begin
					out_q.gate_open      <= next_open;
					out_q.window_used_ms <= swdl_pkg::USED_W'(sum_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// ------------------------------------------------------------- assertions
	a_take_then_init: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> ctl.op == swdl_pkg::OP_INIT)
		else $error("accepted request not followed by init step");

	a_rot_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.op == swdl_pkg::OP_ROT |-> !div_res.busy)
		else $error("rotation used an unfinished quotient");

	a_no_wr_with_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!(ring_req.wr_en && (ring_req.clr_all || ring_req.clr_span)))
		else $error("ring write collides with a clear");

	a_init_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |=> init_q)
		else $error("initialised flag dropped");

	a_wipe_resets_index: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == swdl_pkg::OP_CLRCHK && clr_q) |=> cur_q == '0)
		else $error("ring wipe left a nonzero bucket index");

endmodule
